// File: src/lrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared widths, command codes and cell control type for the LRU recency stack.
// ----------------------------------------------------------------------------
package lrs_pkg;

  localparam int FRAME_W        = 6;
  localparam int CFG_W          = 7;
  localparam int DEF_MAX_FRAMES = 64;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic CMD_REF   = 1'b0;
  localparam logic CMD_EVICT = 1'b1;

  typedef struct packed {
    logic match_en;
    logic shift;
    logic load;
  } lrs_cell_ctrl_t;

endpackage

// File: src/lru_recency_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_recency_stack
// Exact LRU order of occupied page frames kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// The stack is a row of MAX_FRAMES cells, oldest frame at cell 0. Every
// request passes S_IDLE, which accepts it, S_MATCH, in which all cells compare
// their entry with the frame at once, and S_APPLY, in which cells shift toward
// cell 0 where needed and a reference's frame is loaded at the newest
// position. The block takes one request at a time. An evict request returns
// one result (oldest frame and an empty flag) through an output register; a
// reference returns none. The user must write the capacity register through
// cfg_wr_en while no request is in flight; the block does not enforce this.
// Lowering it below the current fill drops the newest entries.
// ----------------------------------------------------------------------------
module lru_recency_stack #(
  parameter int MAX_FRAMES = lrs_pkg::DEF_MAX_FRAMES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_cmd,
  input  logic [lrs_pkg::FRAME_W-1:0]  in_frame_number,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lrs_pkg::FRAME_W-1:0]  out_victim_frame,
  output logic                         out_stack_empty,
  input  logic                         cfg_wr_en,
  input  logic [lrs_pkg::CFG_W-1:0]    cfg_frames_in_use
);
  import lrs_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W = $clog2(MAX_FRAMES);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_APPLY = 3'b100
  } lrs_state_t;

  lrs_state_t         state_r, state_nxt;
  logic               req_cmd_r;
  logic [FRAME_W-1:0] req_frame_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   cap_r, cap_nxt;
  logic [CNT_W-1:0]   cfg_cap;
  logic               out_valid_r;
  logic [FRAME_W-1:0] out_victim_frame_r;
  logic               out_stack_empty_r;

  logic [FRAME_W-1:0] entry [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] hit, prefix;
  lrs_cell_ctrl_t     cell_ctrl [MAX_FRAMES];

  logic               in_acc;
  logic               apply_go;
  logic               hit_any;
  logic               count_zero;
  logic               full;
  logic               shift_all;
  logic               ref_hit;
  logic [IDX_W-1:0]   wpos;

  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CFG_W-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0) begin
      return CNT_W'(1);
    end else if (v32 > 32'(MAX_FRAMES)) begin
      return CNT_W'(MAX_FRAMES);
    end
    return CNT_W'(v32);
  endfunction

  assign cfg_cap    = clamp_cap(cfg_frames_in_use);
  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign hit_any    = prefix[MAX_FRAMES-1];
  assign count_zero = (count_r == '0);
  assign full       = (count_r >= cap_r);
  assign apply_go   = (state_r == S_APPLY) &&
                      !((req_cmd_r == CMD_EVICT) && out_valid_r && out_stall);
  assign shift_all  = ((req_cmd_r == CMD_EVICT) && !count_zero) ||
                      ((req_cmd_r == CMD_REF) && !hit_any && full);
  assign ref_hit    = (req_cmd_r == CMD_REF) && hit_any;

  always_comb begin
    if (hit_any || full) begin
      wpos = IDX_W'(count_r - CNT_W'(1));
    end else begin
      wpos = IDX_W'(count_r);
    end
  end

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    logic [FRAME_W-1:0] nbr;
    if (i == MAX_FRAMES - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = entry[i+1];
    end

    always_comb begin
      cell_ctrl[i].match_en = (state_r == S_MATCH);
      cell_ctrl[i].shift    = apply_go && (shift_all || (ref_hit && prefix[i]));
      cell_ctrl[i].load     = apply_go && (req_cmd_r == CMD_REF) &&
                              (wpos == IDX_W'(i));
    end

    lrs_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (cell_ctrl[i]),
      .occupied    (CNT_W'(i) < count_r),
      .frame_in    (req_frame_r),
      .neighbor_in (nbr),
      .entry_out   (entry[i]),
      .hit_out     (hit[i])
    );
  end

  lrs_prefix #(
    .N (MAX_FRAMES)
  ) u_prefix (
    .hit    (hit),
    .prefix (prefix)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (apply_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    cap_nxt   = cap_r;
    if (cfg_wr_en) begin
      cap_nxt = cfg_cap;
      if (count_r > cfg_cap) begin
        count_nxt = cfg_cap;
      end
    end else if (apply_go) begin
      if ((req_cmd_r == CMD_EVICT) && !count_zero) begin
        count_nxt = count_r - CNT_W'(1);
      end else if ((req_cmd_r == CMD_REF) && !hit_any && !full) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= clamp_cap(CFG_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
      if (apply_go && (req_cmd_r == CMD_EVICT)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_cmd_r   <= in_cmd;
      req_frame_r <= in_frame_number;
    end
    if (apply_go && (req_cmd_r == CMD_EVICT)) begin
      out_victim_frame_r <= count_zero ? '0 : entry[0];
      out_stack_empty_r  <= count_zero;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_victim_frame = out_victim_frame_r;
  assign out_stack_empty  = out_stack_empty_r;

endmodule

// File: src/lrs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_cell
// One stack position: holds a frame, flags a match, loads or takes its
// upper neighbor's entry.
// ----------------------------------------------------------------------------
module lrs_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lrs_pkg::lrs_cell_ctrl_t      ctrl,
  input  logic                         occupied,
  input  logic [lrs_pkg::FRAME_W-1:0]  frame_in,
  input  logic [lrs_pkg::FRAME_W-1:0]  neighbor_in,
  output logic [lrs_pkg::FRAME_W-1:0]  entry_out,
  output logic                         hit_out
);
  import lrs_pkg::*;

  logic [FRAME_W-1:0] entry_r;
  logic               hit_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry_r <= frame_in;
    end else if (ctrl.shift) begin
      entry_r <= neighbor_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctrl.match_en) begin
      hit_r <= occupied && (entry_r == frame_in);
    end
  end

  assign entry_out = entry_r;
  assign hit_out   = hit_r;

endmodule

// File: src/lrs_prefix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_prefix
// Log-depth prefix OR over the cell hit flags: bit i is set when any cell
// at or below position i matched.
// ----------------------------------------------------------------------------
module lrs_prefix #(
  parameter int N = lrs_pkg::DEF_MAX_FRAMES
) (
  input  logic [N-1:0] hit,
  output logic [N-1:0] prefix
);
  import lrs_pkg::*;

  localparam int LV = $clog2(N);

  logic [N-1:0] lvl [LV+1];

  assign lvl[0] = hit;

  for (genvar k = 0; k < LV; k++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << k)) begin : g_or
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1 << k)];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  assign prefix = lvl[LV];

endmodule

// File: src/lrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_checker
// Port-level checks for the LRU recency stack, bound to the top level.
// ----------------------------------------------------------------------------
module lrs_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [lrs_pkg::FRAME_W-1:0]  out_victim_frame,
  input  logic                         out_stack_empty
);
  import lrs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_victim_frame) &&
                               $stable(out_stack_empty))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stack_empty |-> out_victim_frame == '0)
    else $error("empty result carries a nonzero frame");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("request taken while another is in flight");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lru_recency_stack lrs_checker u_lrs_checker (.*);
